/* src/npp_pkg.sv */
`default_nettype none

package npp_pkg;

  // Store geometry
  localparam int unsigned POINT_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(POINT_DEPTH);
  localparam int unsigned CNT_W       = $clog2(POINT_DEPTH + 1);

  // Field widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned RADIUS_W = 15;
  localparam int unsigned PIDX_W   = 8;
  localparam int unsigned POINT_W  = 2 * COORD_W;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned SQ_W     = 2 * COORD_W;
  localparam int unsigned DIST_W   = SQ_W + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(82);

  // Item commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_ADDED  = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_PICKED = 2'd2;
  localparam logic [1:0] STATUS_NONE   = 2'd3;

  // Request to the scan engine
  typedef struct packed {
    logic                       start;
    logic [CNT_W-1:0]           count;
    logic signed [COORD_W-1:0]  qx;
    logic signed [COORD_W-1:0]  qy;
    logic [DIST_W-1:0]          best;
  } scan_req_t;

  // Answer from the scan engine
  typedef struct packed {
    logic                       done;
    logic                       found;
    logic [IDX_W-1:0]           idx;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } scan_rsp_t;

endpackage

`default_nettype wire

/* src/nearest_point_pick.sv */
// Nearest point picker. Holds up to POINT_DEPTH 2-D points (signed Q3.12) in
// a single-port-read synchronous RAM. An add item (cmd 0) appends its point
// and returns status 0 with the slot number, or status 1 when the store is
// full; its result goes through the pending result register to the output
// register. A pick item (cmd 1) streams every stored point out of the RAM,
// one per cycle, through a short difference / square / compare pipeline and
// returns the nearest point, the earlier stored one on a tie, taking a point
// only when its squared distance to the query is strictly below the running
// best, which starts at pick_radius squared; a point at exactly the radius
// is never picked. Status 2 carries the slot and coordinates, status 3 means
// nothing was in range; a pick on an empty store skips the scan. One item is
// worked on at a time; in_stall_o is high while an item is in flight, but a
// finished result may wait in the output register while the next item is
// taken. pick_radius is written through cfg_we_i / cfg_wdata_i and resets
// to 82 (about 0.02).
`default_nettype none

module nearest_point_pick (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [npp_pkg::RADIUS_W-1:0]        cfg_wdata_i,
  // Input items
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                cmd_i,
  input  wire logic signed [npp_pkg::COORD_W-1:0]  x_coord_i,
  input  wire logic signed [npp_pkg::COORD_W-1:0]  y_coord_i,
  // Result items
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               status_o,
  output logic [npp_pkg::PIDX_W-1:0]               point_index_o,
  output logic signed [npp_pkg::COORD_W-1:0]       found_x_o,
  output logic signed [npp_pkg::COORD_W-1:0]       found_y_o
);

  import npp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [RADIUS_W-1:0] radius_q;

  // Pending result, waiting for the output register
  logic [1:0]         res_status_q, res_status_d;
  logic [PIDX_W-1:0]  res_index_q, res_index_d;
  logic [COORD_W-1:0] res_x_q, res_x_d, res_y_q, res_y_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q;
  logic [PIDX_W-1:0]  out_index_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;

  logic                  in_accept;
  logic                  out_free;
  logic                  store_full;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [POINT_W-1:0]    ram_rdata;
  logic [2*RADIUS_W-1:0] radius_sq;
  scan_req_t             scan_req;
  scan_rsp_t             scan_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign store_full = (count_q == CNT_W'(POINT_DEPTH));
  assign radius_sq  = {{RADIUS_W{1'b0}}, radius_q} * {{RADIUS_W{1'b0}}, radius_q};

  // Write the new point at the edge the add item is taken
  assign ram_we = in_accept && (cmd_i == CMD_ADD) && !store_full;

  npp_ram #(
    .WIDTH (POINT_W),
    .DEPTH (POINT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({y_coord_i, x_coord_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Launch a scan only when there is at least one stored point
  assign scan_req.start = in_accept && (cmd_i == CMD_PICK) && (count_q != '0);
  assign scan_req.count = count_q;
  assign scan_req.qx    = x_coord_i;
  assign scan_req.qy    = y_coord_i;
  assign scan_req.best  = DIST_W'(radius_sq);

  npp_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (scan_req),
    .raddr_o (ram_raddr),
    .rdata_i (ram_rdata),
    .rsp_o   (scan_rsp)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_index_d = '0;
          res_x_d     = '0;
          res_y_d     = '0;
          if (cmd_i == CMD_ADD) begin
            state_d = ST_RESP;
            if (store_full) begin
              res_status_d = STATUS_FULL;
            end else begin
              res_status_d = STATUS_ADDED;
              res_index_d  = PIDX_W'(count_q);
              count_d      = count_q + CNT_W'(1);
            end
          end else if (count_q == '0) begin
            // Empty store: nothing to scan
            res_status_d = STATUS_NONE;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Hold until the pipeline has drained, then latch the outcome
        if (scan_rsp.done) begin
          state_d = ST_RESP;
          if (scan_rsp.found) begin
            res_status_d = STATUS_PICKED;
            res_index_d  = PIDX_W'(scan_rsp.idx);
            res_x_d      = scan_rsp.x;
            res_y_d      = scan_rsp.y;
          end else begin
            res_status_d = STATUS_NONE;
          end
        end
      end
      ST_RESP: begin
        // Advance once the output register has room
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      radius_q    <= RADIUS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    if ((state_q == ST_RESP) && out_free) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign point_index_o = out_index_q;
  assign found_x_o     = out_x_q;
  assign found_y_o     = out_y_q;

endmodule

`default_nettype wire

/* src/npp_ram.sv */
`default_nettype none

module npp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/npp_scan.sv */
`default_nettype none

module npp_scan (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire npp_pkg::scan_req_t               req_i,
  output logic      [npp_pkg::IDX_W-1:0]        raddr_o,
  input  wire logic [npp_pkg::POINT_W-1:0]      rdata_i,
  output npp_pkg::scan_rsp_t                    rsp_o
);

  import npp_pkg::*;

  // Read issue
  logic             busy_q, busy_d;
  logic             issuing_q, issuing_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] rd_next;

  // Query and running best
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic [DIST_W-1:0]         best_q, best_d;
  logic                      found_q, found_d;
  logic [IDX_W-1:0]          hit_idx_q, hit_idx_d;
  logic [COORD_W-1:0]        hit_x_q, hit_x_d, hit_y_q, hit_y_d;

  // Pipeline: v0 read data, v1 magnitudes, v2 squares
  logic               v0_q, v1_q, v2_q;
  logic [IDX_W-1:0]   idx0_q, idx1_q, idx2_q;
  logic [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [DIFF_W-1:0]  ax1_q, ay1_q;
  logic [SQ_W-1:0]    sqx2_q, sqy2_q;

  logic [DIFF_W-1:0]   dx, dy, ax, ay;
  logic [2*DIFF_W-1:0] prod_x, prod_y;
  logic [DIST_W-1:0]   sq_dist;
  logic                drain_done;

  assign rd_next = rd_cnt_q + CNT_W'(1);
  assign raddr_o = rd_cnt_q[IDX_W-1:0];

  always_comb begin
    busy_d    = busy_q;
    issuing_d = issuing_q;
    rd_cnt_d  = rd_cnt_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      issuing_d = 1'b1;
      rd_cnt_d  = '0;
    end else if (issuing_q) begin
      rd_cnt_d = rd_next;
      if (rd_next == n_q) begin
        issuing_d = 1'b0;
      end
    end else if (drain_done) begin
      busy_d = 1'b0;
    end
  end

  assign drain_done = busy_q && !issuing_q && !v0_q && !v1_q && !v2_q;

  // Stage 1: coordinate differences and magnitudes
  always_comb begin
    dx = {rdata_i[COORD_W-1], rdata_i[COORD_W-1:0]} - {qx_q[COORD_W-1], qx_q};
    dy = {rdata_i[POINT_W-1], rdata_i[POINT_W-1:COORD_W]} - {qy_q[COORD_W-1], qy_q};
    ax = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
    ay = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
  end

  // Stage 2: squares
  assign prod_x = {{DIFF_W{1'b0}}, ax1_q} * {{DIFF_W{1'b0}}, ax1_q};
  assign prod_y = {{DIFF_W{1'b0}}, ay1_q} * {{DIFF_W{1'b0}}, ay1_q};

  // Stage 3: sum and strict compare against the running best
  assign sq_dist = {1'b0, sqx2_q} + {1'b0, sqy2_q};

  always_comb begin
    best_d    = best_q;
    found_d   = found_q;
    hit_idx_d = hit_idx_q;
    hit_x_d   = hit_x_q;
    hit_y_d   = hit_y_q;
    if (req_i.start) begin
      best_d  = req_i.best;
      found_d = 1'b0;
    end else if (v2_q && (sq_dist < best_q)) begin
      best_d    = sq_dist;
      found_d   = 1'b1;
      hit_idx_d = idx2_q;
      hit_x_d   = x2_q;
      hit_y_d   = y2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      issuing_q <= 1'b0;
      rd_cnt_q  <= '0;
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      issuing_q <= issuing_d;
      rd_cnt_q  <= rd_cnt_d;
      v0_q      <= issuing_q && !req_i.start;
      v1_q      <= v0_q;
      v2_q      <= v1_q;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q  <= req_i.count;
      qx_q <= req_i.qx;
      qy_q <= req_i.qy;
    end
    best_q    <= best_d;
    hit_idx_q <= hit_idx_d;
    hit_x_q   <= hit_x_d;
    hit_y_q   <= hit_y_d;
    idx0_q    <= rd_cnt_q[IDX_W-1:0];
    idx1_q    <= idx0_q;
    x1_q      <= rdata_i[COORD_W-1:0];
    y1_q      <= rdata_i[POINT_W-1:COORD_W];
    ax1_q     <= ax;
    ay1_q     <= ay;
    idx2_q    <= idx1_q;
    x2_q      <= x1_q;
    y2_q      <= y1_q;
    sqx2_q    <= prod_x[SQ_W-1:0];
    sqy2_q    <= prod_y[SQ_W-1:0];
  end

  assign rsp_o.done  = drain_done;
  assign rsp_o.found = found_q;
  assign rsp_o.idx   = hit_idx_q;
  assign rsp_o.x     = hit_x_q;
  assign rsp_o.y     = hit_y_q;

endmodule

`default_nettype wire

/* bench/nearest_point_pick_test.sv */
module nearest_point_pick_test;
  import npp_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 20;
  // Idle limit for the watchdog; allow many times the length of a pick over a full store.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SEGMENT_ITEMS  = 40;
  localparam int COORD_MIN      = -32768;
  localparam int COORD_MAX      = 32767;

  // One answer of the picker, field by field as it leaves the block.
  typedef struct packed {
    logic [1:0]                status;
    logic [PIDX_W-1:0]         index;
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
  } answer_t;

  // Block inputs start at known values; reset is held low from time zero.
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [RADIUS_W-1:0]       cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic                      cmd_i       = CMD_ADD;
  logic signed [COORD_W-1:0] x_coord_i   = '0;
  logic signed [COORD_W-1:0] y_coord_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                status_o;
  logic [PIDX_W-1:0]         point_index_o;
  logic signed [COORD_W-1:0] found_x_o;
  logic signed [COORD_W-1:0] found_y_o;

  // Shadow of the block: stored points (y high, x low), fill level and radius.
  logic [POINT_W-1:0]  point_mem [POINT_DEPTH];
  int unsigned         point_total = 0;
  logic [RADIUS_W-1:0] radius_q    = RADIUS_RESET;

  // Answers owed by the block, oldest first.
  answer_t pending_answers[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;

  nearest_point_pick dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .point_index_o (point_index_o),
    .found_x_o     (found_x_o),
    .found_y_o     (found_y_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Work out the answer to one item and advance the shadow state. An add
  // appends or reports a full store; a pick keeps the first point whose
  // squared distance is strictly below the running best, which starts at
  // the squared radius, so a point exactly on the radius never wins.
  function automatic answer_t predict_answer(input logic cmd,
                                             input logic signed [COORD_W-1:0] qx,
                                             input logic signed [COORD_W-1:0] qy);
    answer_t                   a;
    longint                    best;
    longint                    sq_dist;
    longint                    dx;
    longint                    dy;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    int unsigned               i;
    a = '0;
    if (cmd == CMD_ADD) begin
      if (point_total >= POINT_DEPTH) begin
        a.status = STATUS_FULL;
      end else begin
        point_mem[point_total] = {qy, qx};
        a.status = STATUS_ADDED;
        a.index  = PIDX_W'(point_total);
        point_total++;
      end
    end else begin
      best     = longint'(radius_q) * longint'(radius_q);
      a.status = STATUS_NONE;
      for (i = 0; i < point_total; i++) begin
        px      = point_mem[i][COORD_W-1:0];
        py      = point_mem[i][POINT_W-1:COORD_W];
        dx      = longint'(px) - longint'(qx);
        dy      = longint'(py) - longint'(qy);
        sq_dist = dx * dx + dy * dy;
        if (sq_dist < best) begin
          best     = sq_dist;
          a.status = STATUS_PICKED;
          a.index  = PIDX_W'(i);
          a.fx     = px;
          a.fy     = py;
        end
      end
    end
    return a;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int random_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Spread a coordinate by up to span either way, staying inside Q3.12.
  function automatic int near_coord(input int base, input int span);
    return clamp_coord(base + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic flag_mismatch(input string field, input longint want, input longint got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Receiver: stall at random, at the rate the current phase asks.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check every answer taken from the block against the oldest one owed.
  always @(posedge clk_i) begin : check_answers
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("%0t: answer with none owed, status %0d index %0d x %0d y %0d",
                 $time, status_o, point_index_o, found_x_o, found_y_o);
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status) flag_mismatch("status", want.status, status_o);
        if (point_index_o !== want.index) flag_mismatch("point_index", want.index, point_index_o);
        if (found_x_o !== want.fx) flag_mismatch("found_x", want.fx, found_x_o);
        if (found_y_o !== want.fy) flag_mismatch("found_y", want.fy, found_y_o);
      end
    end
  end

  // Watchdog: end the run once nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one item after a random gap, hold it until taken, then log the
  // answer it is owed. Valid stays high straight into the next item when no
  // gap is drawn.
  task automatic send_item(input logic cmd, input int x, input int y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    x_coord_i  <= COORD_W'(x);
    y_coord_i  <= COORD_W'(y);
    do @(posedge clk_i); while (in_stall_o);
    pending_answers = {pending_answers, predict_answer(cmd, COORD_W'(x), COORD_W'(y))};
  endtask

  // Drop valid and wait until every owed answer is in. Each item yields an
  // answer, so an empty list means the block is idle; settle a little more.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    drain_answers();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_q     = value;
    @(posedge clk_i);
  endtask

  function automatic logic [RADIUS_W-1:0] random_radius();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return RADIUS_RESET;
      3:       return RADIUS_W'($urandom_range(1, 32767));
      default: return RADIUS_W'($urandom_range(1, 600));
    endcase
  endfunction

  // Pick on an empty store: nothing can be in range, whatever the query.
  task automatic test_empty_store();
    send_item(CMD_PICK, 0, 0);
    send_item(CMD_PICK, COORD_MIN, COORD_MAX);
  endtask

  // Corners, origin, a point on the radius and a tie, at the reset radius.
  task automatic test_directed_points();
    send_item(CMD_ADD, COORD_MIN, COORD_MIN);
    send_item(CMD_ADD, COORD_MAX, COORD_MAX);
    send_item(CMD_ADD, COORD_MIN, COORD_MAX);
    send_item(CMD_ADD, COORD_MAX, COORD_MIN);
    send_item(CMD_ADD, 0, 0);
    send_item(CMD_ADD, 82, 0);
    // Two points equally near (1000, 1000): the first stored must win.
    send_item(CMD_ADD, 1050, 1000);
    send_item(CMD_ADD, 950, 1000);
    send_item(CMD_PICK, COORD_MAX, COORD_MAX);
    send_item(CMD_PICK, COORD_MIN, COORD_MIN);
    send_item(CMD_PICK, COORD_MAX, COORD_MIN);
    send_item(CMD_PICK, COORD_MIN, COORD_MAX);
    send_item(CMD_PICK, -1, -1);
    // Exactly on the radius from (82, 0): not picked; one unit closer: picked.
    send_item(CMD_PICK, 164, 0);
    send_item(CMD_PICK, 163, 0);
    send_item(CMD_PICK, 1000, 1000);
    send_item(CMD_PICK, 20000, -20000);
  endtask

  // Zero radius picks nothing even at distance zero; the widest radius
  // reaches across most of the plane.
  task automatic test_radius_extremes();
    write_radius('0);
    send_item(CMD_PICK, 0, 0);
    send_item(CMD_PICK, 1050, 1000);
    write_radius('1);
    send_item(CMD_PICK, 16384, 16384);
    send_item(CMD_PICK, COORD_MIN, 0);
    write_radius(RADIUS_RESET);
    send_item(CMD_PICK, 163, 0);
  endtask

  // Mixed traffic: adds, often clustered near stored points, and picks,
  // mostly aimed near a stored point so the radius decides. Change the
  // radius between segments.
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned sender_pct,
                                     input int unsigned receiver_pct);
    int unsigned  k;
    int unsigned  slot;
    int           span;
    logic [POINT_W-1:0] p;
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    for (k = 0; k < n_items; k++) begin
      if (k % SEGMENT_ITEMS == 0) write_radius(random_radius());
      if (point_total != 0) begin
        slot = $urandom_range(point_total - 1);
        p    = point_mem[slot];
      end
      if ($urandom_range(99) < 30) begin
        if (point_total != 0 && $urandom_range(1)) begin
          send_item(CMD_ADD, near_coord(int'($signed(p[COORD_W-1:0])), 200),
                    near_coord(int'($signed(p[POINT_W-1:COORD_W])), 200));
        end else begin
          send_item(CMD_ADD, random_coord(), random_coord());
        end
      end else if (point_total != 0 && $urandom_range(99) < 75) begin
        span = int'(radius_q) + 16;
        send_item(CMD_PICK, near_coord(int'($signed(p[COORD_W-1:0])), span),
                  near_coord(int'($signed(p[POINT_W-1:COORD_W])), span));
      end else begin
        send_item(CMD_PICK, random_coord(), random_coord());
      end
    end
  endtask

  // Fill the store to the brim, overflow it twice, then pick its first and
  // last slots.
  task automatic test_full_store();
    logic [POINT_W-1:0] p;
    while (point_total < POINT_DEPTH) send_item(CMD_ADD, random_coord(), random_coord());
    send_item(CMD_ADD, 0, 0);
    send_item(CMD_ADD, COORD_MAX, COORD_MIN);
    write_radius(RADIUS_RESET);
    p = point_mem[POINT_DEPTH-1];
    send_item(CMD_PICK, int'($signed(p[COORD_W-1:0])), int'($signed(p[POINT_W-1:COORD_W])));
    p = point_mem[0];
    send_item(CMD_PICK, int'($signed(p[COORD_W-1:0])), int'($signed(p[POINT_W-1:COORD_W])));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_directed_points();
    test_radius_extremes();
    // Sender idles lightly, receiver heavily; then the reverse; then neither.
    test_random_traffic(320, 12, 57);
    test_random_traffic(320, 57, 12);
    test_random_traffic(320, 0, 0);
    test_full_store();

    drain_answers();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/npp_pkg.sv
src/npp_ram.sv
src/npp_scan.sv
src/nearest_point_pick.sv
bench/nearest_point_pick_test.sv
